// ===== rtl/torus_vertex_generator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Torus vertex generator assertion macros
// Shared concurrent assertion wrappers for the torus vertex generator.
// ----------------------------------------------------------------------------
`ifndef TORUS_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`define TORUS_VERTEX_GENERATOR_UNIT_DEFINES_SVH

// explicit clock and active-low reset
`define TVG_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// default clock and reset of the block
`define TVG_ASSERT(lbl, prop, msg) \
  `TVG_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/tvg_pkg.sv =====
// ----------------------------------------------------------------------------
// Torus vertex generator package
// Shared constants, register codes and sine polynomial coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package tvg_pkg;

  localparam int FRAC_BITS_DEF  = 14;
  localparam int PHASE_BITS_DEF = 16;
  localparam int INDEX_BITS_DEF = 8;

  localparam int RAD_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int Q30_W      = 31;

  localparam logic [RAD_W-1:0] RING_RADIUS_RST = 15'd8192;
  localparam logic [RAD_W-1:0] TUBE_RADIUS_RST = 15'd3277;
  localparam int               SEGMENTS_RST    = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_RADIUS = 2'd0,
    CFG_TUBE_RADIUS = 2'd1,
    CFG_SEGMENTS    = 2'd2
  } cfg_reg_e;

  // odd Taylor terms of sin(pi/2 * x), Q30
  localparam logic [Q30_W-1:0] K1 = 31'd1686629713;
  localparam logic [Q30_W-1:0] K3 = 31'd693598668;
  localparam logic [Q30_W-1:0] K5 = 31'd85569306;
  localparam logic [Q30_W-1:0] K7 = 31'd5026995;
  localparam logic [Q30_W-1:0] K9 = 31'd172272;
  localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;

  // coefficient subtracted in Horner step k (after K9)
  function automatic logic [Q30_W-1:0] horner_coef(input logic [1:0] step);
    logic [Q30_W-1:0] c;
    unique case (step)
      2'd0:    c = K7;
      2'd1:    c = K5;
      2'd2:    c = K3;
      default: c = K1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tvg_if.sv =====
// ----------------------------------------------------------------------------
// Torus vertex generator channels
// Grid point input, vertex output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvg_in_if import tvg_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] ring_index;
  logic [INDEX_BITS-1:0] vertex_index;

  modport source (output valid, ring_index, vertex_index, input ready);
  modport sink   (input valid, ring_index, vertex_index, output ready);
endinterface

interface tvg_out_if import tvg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+2:0] pos_x;
  logic signed [FRAC_BITS+2:0] pos_y;
  logic signed [FRAC_BITS+2:0] pos_z;
  logic signed [FRAC_BITS+1:0] normal_x;
  logic signed [FRAC_BITS+1:0] normal_y;
  logic signed [FRAC_BITS+1:0] normal_z;
  logic signed [FRAC_BITS+1:0] tangent_x;
  logic signed [FRAC_BITS+1:0] tangent_y;
  logic signed [FRAC_BITS+1:0] tangent_z;
  logic        [FRAC_BITS+1:0] tex_s;
  logic        [FRAC_BITS:0]   tex_t;
  logic                        index_error;

  modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  tangent_x, tangent_y, tangent_z, tex_s, tex_t, index_error,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  tangent_x, tangent_y, tangent_z, tex_s, tex_t, index_error,
                  output ready);
endinterface

interface tvg_cfg_if import tvg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tvg_div.sv =====
// ----------------------------------------------------------------------------
// Torus vertex generator divider pipeline
// Restoring long division, one quotient bit per stage, parallel lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module tvg_div #(
  parameter int LANES = 4,
  parameter int NUM_W = 25,
  parameter int DEN_W = 8,
  parameter int SB_W  = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]            den_i,
  input  logic [SB_W-1:0]             sb_i,
  output logic                        valid_o,
  output logic [LANES-1:0][NUM_W-1:0] quo_o,
  output logic [SB_W-1:0]             sb_o
);

  logic                        valid_q [NUM_W];
  logic [SB_W-1:0]             sb_q    [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] rem_q   [NUM_W];
  // numerator bits shift out the top, quotient bits shift in the bottom
  logic [LANES-1:0][NUM_W-1:0] nq_q    [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic                        v_in;
    logic [SB_W-1:0]             sb_in;
    logic [LANES-1:0][DEN_W-1:0] rem_in;
    logic [LANES-1:0][NUM_W-1:0] nq_in;
    logic [LANES-1:0][DEN_W-1:0] rem_d;
    logic [LANES-1:0][NUM_W-1:0] nq_d;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign sb_in  = sb_i;
      assign rem_in = '0;
      assign nq_in  = num_i;
    end else begin : g_next
      assign v_in   = valid_q[s-1];
      assign sb_in  = sb_q[s-1];
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
    end

    always_comb begin
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           qbit;
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_in[l], nq_in[l][NUM_W-1]};
        diff  = trial - {1'b0, den_i};
        qbit  = (trial >= {1'b0, den_i});
        rem_d[l] = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_d[l]  = {nq_in[l][NUM_W-2:0], qbit};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[s]  <= sb_in;
        rem_q[s] <= rem_d;
        nq_q[s]  <= nq_d;
      end
    end
  end

  assign valid_o = valid_q[NUM_W-1];
  assign sb_o    = sb_q[NUM_W-1];
  assign quo_o   = nq_q[NUM_W-1];

endmodule

`default_nettype wire

// ===== rtl/tvg_sin.sv =====
// ----------------------------------------------------------------------------
// Torus vertex generator sine pipeline
// Quadrant fold, Horner polynomial over Q30, rounding to Q.FRAC_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module tvg_sin import tvg_pkg::*; #(
  parameter int LANES      = 4,
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int SB_W       = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [LANES-1:0][PHASE_BITS-1:0]     phase_i,
  input  logic [SB_W-1:0]                      sb_i,
  output logic                                 valid_o,
  output logic [LANES-1:0][FRAC_BITS+1:0]      sin_o,
  output logic [SB_W-1:0]                      sb_o
);

  localparam int UW     = FRAC_BITS + 2;
  localparam int STAGES = 7;
  localparam logic [Q30_W:0] ONE_W = (Q30_W+1)'(1) << FRAC_BITS;
  localparam logic [Q30_W:0] HALF_W = (Q30_W+1)'(1) << (29 - FRAC_BITS);

  logic            valid_q [STAGES];
  logic [SB_W-1:0] sb_q    [STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) valid_q[k] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 1; k < STAGES; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= sb_i;
      for (int k = 1; k < STAGES; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [Q30_W-1:0] x_q  [5];
    logic [Q30_W-1:0] x2_q [4];
    logic [Q30_W-1:0] h_q  [4];
    logic [1:0]       q_q  [6];
    logic [Q30_W-1:0] s_q;
    logic [UW-1:0]    out_q;

    logic [Q30_W-1:0] x_d, x2_d, s_d;
    logic [1:0]       q_d;
    logic [Q30_W-1:0] h_d [4];
    logic [UW-1:0]    out_d;

    // quadrant fold and x^2
    always_comb begin
      logic [Q30_W-1:0]   xr;
      logic [2*Q30_W-1:0] sq;
      q_d = phase_i[l][PHASE_BITS-1 -: 2];
      xr  = Q30_W'(phase_i[l][PHASE_BITS-3:0]) << (32 - PHASE_BITS);
      x_d = q_d[0] ? (Q30_ONE - xr) : xr;
      sq  = x_d * x_d;
      x2_d = sq[30 +: Q30_W];
    end

    // one Horner step per stage
    always_comb begin
      logic [2*Q30_W-1:0] pr;
      logic [Q30_W-1:0]   h_in;
      for (int k = 0; k < 4; k++) begin
        h_in   = (k == 0) ? K9 : h_q[(k == 0) ? 0 : k-1];
        pr     = x2_q[k] * h_in;
        h_d[k] = horner_coef(2'(k)) - pr[30 +: Q30_W];
      end
    end

    always_comb begin
      logic [2*Q30_W-1:0] pr;
      pr  = x_q[4] * h_q[3];
      s_d = pr[30 +: Q30_W];
    end

    // round half up, cap at one, apply quadrant sign
    always_comb begin
      logic [Q30_W:0] sum;
      logic [Q30_W:0] r;
      logic [UW-1:0]  mag;
      sum   = {1'b0, s_q} + HALF_W;
      r     = sum >> (30 - FRAC_BITS);
      mag   = (r > ONE_W) ? ONE_W[UW-1:0] : r[UW-1:0];
      out_d = q_q[5][1] ? (UW'(0) - mag) : mag;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[0]  <= x_d;
        x2_q[0] <= x2_d;
        q_q[0]  <= q_d;
        for (int k = 1; k < 5; k++) x_q[k]  <= x_q[k-1];
        for (int k = 1; k < 4; k++) x2_q[k] <= x2_q[k-1];
        for (int k = 1; k < 6; k++) q_q[k]  <= q_q[k-1];
        for (int k = 0; k < 4; k++) h_q[k]  <= h_d[k];
        s_q   <= s_d;
        out_q <= out_d;
      end
    end

    assign sin_o[l] = out_q;
  end

  assign valid_o = valid_q[STAGES-1];
  assign sb_o    = sb_q[STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/tvg_mix.sv =====
// ----------------------------------------------------------------------------
// Torus vertex generator product pipeline
// Products of ring and tube terms, rounding, saturation, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tvg_mix import tvg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SB_W      = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [FRAC_BITS+1:0] st_i,
  input  logic signed [FRAC_BITS+1:0] ct_i,
  input  logic signed [FRAC_BITS+1:0] sp_i,
  input  logic signed [FRAC_BITS+1:0] cp_i,
  input  logic [RAD_W-1:0]            ring_radius_i,
  input  logic [RAD_W-1:0]            tube_radius_i,
  input  logic [SB_W-1:0]             sb_i,
  output logic                        valid_o,
  output logic signed [FRAC_BITS+2:0] pos_x_o,
  output logic signed [FRAC_BITS+2:0] pos_y_o,
  output logic signed [FRAC_BITS+2:0] pos_z_o,
  output logic signed [FRAC_BITS+1:0] normal_x_o,
  output logic signed [FRAC_BITS+1:0] normal_y_o,
  output logic signed [FRAC_BITS+1:0] normal_z_o,
  output logic signed [FRAC_BITS+1:0] tangent_x_o,
  output logic signed [FRAC_BITS+1:0] tangent_y_o,
  output logic signed [FRAC_BITS+1:0] tangent_z_o,
  output logic [SB_W-1:0]             sb_o
);

  localparam int UW     = FRAC_BITS + 2;
  localparam int PW     = FRAC_BITS + 3;
  localparam int AW     = RAD_W + 1;
  localparam int RHO_W  = RAD_W + 3;
  localparam int AP_W   = AW + UW;
  localparam int UP_W   = 2 * UW;
  localparam int RP_W   = UW + RHO_W;
  localparam int CW     = RP_W + 1;
  localparam int STAGES = 4;
  localparam logic signed [CW-1:0] PMAX = (CW'(1) << (PW - 1)) - CW'(1);
  localparam logic signed [CW-1:0] PMIN = CW'(0) - (CW'(1) << (PW - 1));

  logic            valid_q [STAGES];
  logic [SB_W-1:0] sb_q    [STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) valid_q[k] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 1; k < STAGES; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= sb_i;
      for (int k = 1; k < STAGES; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  // stage 1: raw products
  logic signed [AP_W-1:0] p_ast_q, p_act_q;
  logic signed [UP_W-1:0] p_nx_q, p_nz_q, p_tx_q, p_tz_q;
  logic signed [UW-1:0]   cp1_q, nsp1_q, st1_q, ct1_q;
  logic signed [AW-1:0]   a_s;
  logic signed [UW-1:0]   ncp, nsp;

  assign a_s = {1'b0, tube_radius_i};
  assign ncp = UW'(0) - cp_i;
  assign nsp = UW'(0) - sp_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ast_q <= a_s * st_i;
      p_act_q <= a_s * ct_i;
      p_nx_q  <= ncp * st_i;
      p_nz_q  <= sp_i * st_i;
      p_tx_q  <= cp_i * ct_i;
      p_tz_q  <= nsp * ct_i;
      cp1_q   <= cp_i;
      nsp1_q  <= nsp;
      st1_q   <= st_i;
      ct1_q   <= ct_i;
    end
  end

  // stage 2: rounding, tube radius term
  logic signed [RHO_W-1:0] rho_q;
  logic signed [PW-1:0]    py2_q;
  logic signed [UW-1:0]    nx2_q, ny2_q, nz2_q, tx2_q, ty2_q, tz2_q, cp2_q, nsp2_q;
  logic signed [RHO_W-1:0] rho_d;
  logic signed [PW-1:0]    py_d;
  logic signed [UW-1:0]    nx_d, nz_d, tx_d, tz_d;

  always_comb begin
    logic signed [AP_W-1:0] sa, sy;
    logic signed [AP_W-1:0] ra, ry;
    logic signed [UP_W-1:0] s0, s1, s2, s3;
    logic signed [UP_W-1:0] r0, r1, r2, r3;
    logic signed [CW-1:0]   ey;
    sa = p_ast_q + (AP_W'(1) << (FRAC_BITS - 1));
    sy = p_act_q + (AP_W'(1) << (FRAC_BITS - 1));
    ra = sa >>> FRAC_BITS;
    ry = sy >>> FRAC_BITS;
    rho_d = $signed({3'b000, ring_radius_i}) - ra[RHO_W-1:0];
    ey = CW'(ry);
    if (ey > PMAX) begin
      py_d = PMAX[PW-1:0];
    end else if (ey < PMIN) begin
      py_d = PMIN[PW-1:0];
    end else begin
      py_d = ey[PW-1:0];
    end
    s0 = p_nx_q + (UP_W'(1) << (FRAC_BITS - 1));
    s1 = p_nz_q + (UP_W'(1) << (FRAC_BITS - 1));
    s2 = p_tx_q + (UP_W'(1) << (FRAC_BITS - 1));
    s3 = p_tz_q + (UP_W'(1) << (FRAC_BITS - 1));
    r0 = s0 >>> FRAC_BITS;
    r1 = s1 >>> FRAC_BITS;
    r2 = s2 >>> FRAC_BITS;
    r3 = s3 >>> FRAC_BITS;
    nx_d = r0[UW-1:0];
    nz_d = r1[UW-1:0];
    tx_d = r2[UW-1:0];
    tz_d = r3[UW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rho_q  <= rho_d;
      py2_q  <= py_d;
      nx2_q  <= nx_d;
      ny2_q  <= ct1_q;
      nz2_q  <= nz_d;
      tx2_q  <= tx_d;
      ty2_q  <= st1_q;
      tz2_q  <= tz_d;
      cp2_q  <= cp1_q;
      nsp2_q <= nsp1_q;
    end
  end

  // stage 3: ring products
  logic signed [RP_W-1:0] p_px_q, p_pz_q;
  logic signed [PW-1:0]   py3_q;
  logic signed [UW-1:0]   nx3_q, ny3_q, nz3_q, tx3_q, ty3_q, tz3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_px_q <= cp2_q * rho_q;
      p_pz_q <= nsp2_q * rho_q;
      py3_q  <= py2_q;
      nx3_q  <= nx2_q;
      ny3_q  <= ny2_q;
      nz3_q  <= nz2_q;
      tx3_q  <= tx2_q;
      ty3_q  <= ty2_q;
      tz3_q  <= tz2_q;
    end
  end

  // stage 4: round, saturate, output register
  logic signed [PW-1:0] px_d, pz_d;

  always_comb begin
    logic signed [RP_W-1:0] sx, sz, rx, rz;
    logic signed [CW-1:0]   ex, ez;
    sx = p_px_q + (RP_W'(1) << (FRAC_BITS - 1));
    sz = p_pz_q + (RP_W'(1) << (FRAC_BITS - 1));
    rx = sx >>> FRAC_BITS;
    rz = sz >>> FRAC_BITS;
    ex = CW'(rx);
    ez = CW'(rz);
    if (ex > PMAX) begin
      px_d = PMAX[PW-1:0];
    end else if (ex < PMIN) begin
      px_d = PMIN[PW-1:0];
    end else begin
      px_d = ex[PW-1:0];
    end
    if (ez > PMAX) begin
      pz_d = PMAX[PW-1:0];
    end else if (ez < PMIN) begin
      pz_d = PMIN[PW-1:0];
    end else begin
      pz_d = ez[PW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_x_o     <= px_d;
      pos_y_o     <= py3_q;
      pos_z_o     <= pz_d;
      normal_x_o  <= nx3_q;
      normal_y_o  <= ny3_q;
      normal_z_o  <= nz3_q;
      tangent_x_o <= tx3_q;
      tangent_y_o <= ty3_q;
      tangent_z_o <= tz3_q;
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign sb_o    = sb_q[STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/torus_vertex_generator_unit.sv =====
// Throughput: one vertex per cycle; the divider, sine and product stages all stall
// together while the output register holds an untaken vertex.
// Depth is set by the long-division pipeline, one quotient bit per stage.
// Reset: async active low; clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// Torus vertex generator
// Grid point to torus vertex position, normal, tangent and texture coordinates.
// ----------------------------------------------------------------------------
`default_nettype none
`include "torus_vertex_generator_unit_defines.svh"

module torus_vertex_generator_unit import tvg_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tvg_in_if.sink          in_i,
  tvg_out_if.source       out_o,
  tvg_cfg_if.sink         cfg_i
);

  localparam int TS_W  = FRAC_BITS + 2;
  localparam int TT_W  = FRAC_BITS + 1;
  localparam int UW    = FRAC_BITS + 2;
  localparam int NUM_A = INDEX_BITS + PHASE_BITS;
  localparam int NUM_B = INDEX_BITS + FRAC_BITS + 1;
  localparam int NUM_W = ((NUM_A > NUM_B) ? NUM_A : NUM_B) + 1;
  localparam int SB_W  = 1 + TS_W + TT_W;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);
  localparam logic [NUM_W-1:0] TS_MAX_N = NUM_W'(1) << (FRAC_BITS + 1);
  localparam logic [NUM_W-1:0] TT_MAX_N = NUM_W'(1) << FRAC_BITS;
  localparam logic [TS_W-1:0]  TS_MAX = TS_W'(1) << (FRAC_BITS + 1);
  localparam logic [TT_W-1:0]  TT_MAX = TT_W'(1) << FRAC_BITS;
  localparam logic signed [UW-1:0] UNIT_HI = UW'(1) << FRAC_BITS;
  localparam logic signed [UW-1:0] UNIT_LO = UW'(0) - (UW'(1) << FRAC_BITS);

  // configuration registers
  logic [RAD_W-1:0]      ring_radius_q, tube_radius_q;
  logic [INDEX_BITS-1:0] segments_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_radius_q <= RING_RADIUS_RST;
      tube_radius_q <= TUBE_RADIUS_RST;
      segments_q    <= INDEX_BITS'(SEGMENTS_RST);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_RING_RADIUS: ring_radius_q <= cfg_i.data[RAD_W-1:0];
        CFG_TUBE_RADIUS: tube_radius_q <= cfg_i.data[RAD_W-1:0];
        CFG_SEGMENTS:    segments_q    <= cfg_i.data[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // global stall while the output register holds an untaken vertex
  logic en;
  logic out_valid;

  assign en          = !(out_valid && !out_o.ready);
  assign in_i.ready  = en;
  assign out_o.valid = out_valid;

  // division front end
  logic [INDEX_BITS-1:0]          den;
  logic [NUM_W-1:0]               half_den;
  logic                           idx_err;
  logic [3:0][NUM_W-1:0]          num;

  assign den      = (segments_q == '0) ? INDEX_BITS'(1) : segments_q;
  assign half_den = NUM_W'(den >> 1);
  assign idx_err  = (in_i.ring_index > segments_q) || (in_i.vertex_index > segments_q);
  assign num[0]   = (NUM_W'(in_i.vertex_index) << PHASE_BITS) + half_den;
  assign num[1]   = (NUM_W'(in_i.ring_index) << PHASE_BITS) + half_den;
  assign num[2]   = (NUM_W'(in_i.ring_index) << (FRAC_BITS + 1)) + half_den;
  assign num[3]   = (NUM_W'(in_i.vertex_index) << FRAC_BITS) + half_den;

  logic                  div_valid;
  logic [3:0][NUM_W-1:0] quo;
  logic                  div_err;

  tvg_div #(
    .LANES (4),
    .NUM_W (NUM_W),
    .DEN_W (INDEX_BITS),
    .SB_W  (1)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .num_i   (num),
    .den_i   (den),
    .sb_i    (idx_err),
    .valid_o (div_valid),
    .quo_o   (quo),
    .sb_o    (div_err)
  );

  // phases and texture coordinates
  logic [PHASE_BITS-1:0]       pth, pph;
  logic [3:0][PHASE_BITS-1:0]  phases;
  logic [TS_W-1:0]             ts;
  logic [TT_W-1:0]             tt;

  assign pth       = quo[0][PHASE_BITS-1:0];
  assign pph       = quo[1][PHASE_BITS-1:0];
  assign phases[0] = pth;
  assign phases[1] = pth + QUARTER;
  assign phases[2] = pph;
  assign phases[3] = pph + QUARTER;
  assign ts = (quo[2] > TS_MAX_N) ? TS_MAX : quo[2][TS_W-1:0];
  assign tt = (quo[3] > TT_MAX_N) ? TT_MAX : quo[3][TT_W-1:0];

  logic                  sin_valid;
  logic [3:0][UW-1:0]    sines;
  logic [SB_W-1:0]       sin_sb;

  tvg_sin #(
    .LANES      (4),
    .PHASE_BITS (PHASE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .SB_W       (SB_W)
  ) u_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .phase_i (phases),
    .sb_i    ({div_err, ts, tt}),
    .valid_o (sin_valid),
    .sin_o   (sines),
    .sb_o    (sin_sb)
  );

  logic [SB_W-1:0] mix_sb;

  tvg_mix #(
    .FRAC_BITS (FRAC_BITS),
    .SB_W      (SB_W)
  ) u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (sin_valid),
    .st_i          (sines[0]),
    .ct_i          (sines[1]),
    .sp_i          (sines[2]),
    .cp_i          (sines[3]),
    .ring_radius_i (ring_radius_q),
    .tube_radius_i (tube_radius_q),
    .sb_i          (sin_sb),
    .valid_o       (out_valid),
    .pos_x_o       (out_o.pos_x),
    .pos_y_o       (out_o.pos_y),
    .pos_z_o       (out_o.pos_z),
    .normal_x_o    (out_o.normal_x),
    .normal_y_o    (out_o.normal_y),
    .normal_z_o    (out_o.normal_z),
    .tangent_x_o   (out_o.tangent_x),
    .tangent_y_o   (out_o.tangent_y),
    .tangent_z_o   (out_o.tangent_z),
    .sb_o          (mix_sb)
  );

  assign out_o.index_error = mix_sb[SB_W-1];
  assign out_o.tex_s       = mix_sb[TT_W +: TS_W];
  assign out_o.tex_t       = mix_sb[TT_W-1:0];

  `TVG_ASSERT(a_ready_when_empty, !out_valid |-> in_i.ready, "input stalled with empty output")
  `TVG_ASSERT(a_tex_t_range, out_valid |-> (out_o.tex_t <= TT_MAX), "tex_t above one")
  `TVG_ASSERT(a_tex_s_range, out_valid |-> (out_o.tex_s <= TS_MAX), "tex_s above two")
  `TVG_ASSERT(a_normal_y_range, out_valid |-> ((out_o.normal_y <= UNIT_HI) && (out_o.normal_y >= UNIT_LO)), "normal_y out of unit range")

endmodule

`default_nettype wire
